>>> rtl/plb_pkg.sv
// Shared types and constants of the PRP list builder.
// Used by the sequencer and the top level.
package plb_pkg;

  localparam int unsigned MAX_RESULTS = 64;

  localparam int unsigned PS_W = 17;
  localparam logic [4:0] SHIFT_MIN = 5'd6;
  localparam logic [4:0] SHIFT_MAX = 5'd16;

  localparam logic [1:0] REG_PG_LOG2 = 2'd0;
  localparam logic [1:0] REG_POOL_BASE = 2'd1;
  localparam logic [1:0] REG_POOL_CAPACITY = 2'd2;

  localparam logic [4:0] PG_LOG2_RST = 5'd12;
  localparam logic [63:0] POOL_BASE_RST = 64'd0;
  localparam logic [6:0] POOL_CAPACITY_RST = 7'd64;

  typedef struct packed {
    logic [4:0]  pg_log2;
    logic [63:0] pool_base;
    logic [6:0]  pool_capacity;
  } cfg_t;

  typedef struct packed {
    logic [63:0] write_addr;
    logic [63:0] write_value;
    logic        write_valid;
    logic [63:0] pointer2;
    logic        status;
    logic        last;
  } res_t;

endpackage

>>> rtl/plb_in_if.sv
// Request channel of the PRP list builder: buffer address and byte length.
// No dependencies.
interface plb_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] buffer_addr;
  logic [30:0] byte_length;

  modport source (output valid, output buffer_addr, output byte_length, input ready);
  modport sink (input valid, input buffer_addr, input byte_length, output ready);
endinterface

>>> rtl/plb_out_if.sv
// Result channel of the PRP list builder: list writes, pointer2 and status.
// No dependencies.
interface plb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] write_addr;
  logic [63:0] write_value;
  logic        write_valid;
  logic [63:0] pointer2;
  logic        status;
  logic        last;

  modport source (output valid, output write_addr, output write_value, output write_valid,
                  output pointer2, output status, output last, input ready);
  modport sink (input valid, input write_addr, input write_value, input write_valid,
                input pointer2, input status, input last, output ready);
endinterface

>>> rtl/plb_alu.sv
// Shared 64-bit add/subtract unit with carry out, used for every wide sum and compare.
// No dependencies.
module plb_alu (
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        sub,
  output logic [63:0] sum,
  output logic        cout
);

  logic [64:0] full;

  assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {64'd0, sub};
  assign sum  = full[63:0];
  assign cout = full[64];

endmodule

>>> rtl/plb_seq.sv
// Sequencer of the PRP list builder: drives the shared adder step by step and
// holds the result register. Depends on plb_pkg and plb_alu.
module plb_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  plb_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [63:0]      in_buffer_addr,
  input  logic [30:0]      in_byte_length,
  output logic             out_valid,
  input  logic             out_ready,
  output plb_pkg::res_t    out_res
);
  import plb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_ADDR  = 4'd2;
  localparam logic [3:0] S_CHK2  = 4'd3;
  localparam logic [3:0] S_NCALC = 4'd4;
  localparam logic [3:0] S_CAP   = 4'd5;
  localparam logic [3:0] S_LINKS = 4'd6;
  localparam logic [3:0] S_TOTAL = 4'd7;
  localparam logic [3:0] S_WRITE = 4'd8;
  localparam logic [3:0] S_STEP  = 4'd9;

  logic [3:0]      st_r, st_nxt;
  logic [63:0]     addr_r, addr_nxt;
  logic [30:0]     blen_r, blen_nxt;
  logic [4:0]      sh_r, sh_nxt;
  logic [PS_W-1:0] ps_r, ps_nxt;
  logic [PS_W-1:0] first_r, first_nxt;
  logic [31:0]     rest_r, rest_nxt;
  logic [26:0]     n_r, n_nxt;
  logic [6:0]      rem_r, rem_nxt;
  logic [4:0]      links_r, links_nxt;
  logic [6:0]      entries_left_r, entries_left_nxt;
  logic [12:0]     slot_index_r, slot_index_nxt;
  logic [63:0]     next_page_addr_r, next_page_addr_nxt;
  logic [63:0]     list_page_addr_r, list_page_addr_nxt;
  logic [63:0]     slot_addr_r, slot_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            res_r, res_nxt;

  logic [4:0]      sh_c;
  logic [PS_W-1:0] ps_c;
  logic [12:0]     slots_m1;
  logic [7:0]      total;
  logic            out_free;
  logic            load_res;
  logic [63:0]     alu_a, alu_b, alu_sum;
  logic            alu_sub, alu_cout;
  logic [32:0]     n_sum;

  plb_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  assign sh_c = (cfg.pg_log2 < SHIFT_MIN) ? SHIFT_MIN :
                ((cfg.pg_log2 > SHIFT_MAX) ? SHIFT_MAX : cfg.pg_log2);
  assign ps_c = PS_W'(1) << sh_c;
  assign slots_m1 = 13'((ps_r >> 3) - PS_W'(1));
  assign total = {1'b0, n_r[6:0]} + {3'b0, links_r};
  assign out_free = !out_valid_r || out_ready;
  assign n_sum = alu_sum[32:0] >> sh_r;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    st_nxt = st_r;
    addr_nxt = addr_r;
    blen_nxt = blen_r;
    sh_nxt = sh_r;
    ps_nxt = ps_r;
    first_nxt = first_r;
    rest_nxt = rest_r;
    n_nxt = n_r;
    rem_nxt = rem_r;
    links_nxt = links_r;
    entries_left_nxt = entries_left_r;
    slot_index_nxt = slot_index_r;
    next_page_addr_nxt = next_page_addr_r;
    list_page_addr_nxt = list_page_addr_r;
    slot_addr_nxt = slot_addr_r;
    alu_a = '0;
    alu_b = '0;
    alu_sub = 1'b0;
    load_res = 1'b0;
    res_nxt = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          addr_nxt = in_buffer_addr;
          blen_nxt = in_byte_length;
          sh_nxt = sh_c;
          ps_nxt = ps_c;
          first_nxt = ps_c - (in_buffer_addr[PS_W-1:0] & (ps_c - PS_W'(1)));
          st_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        alu_a = {33'd0, blen_r};
        alu_b = {47'd0, first_r};
        alu_sub = 1'b1;
        if (!alu_cout || alu_sum == 64'd0) begin
          if (out_free) begin
            load_res = 1'b1;
            res_nxt.last = 1'b1;
            st_nxt = S_IDLE;
          end
        end else begin
          rest_nxt = alu_sum[31:0];
          st_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        alu_a = addr_r;
        alu_b = {47'd0, first_r};
        next_page_addr_nxt = alu_sum;
        st_nxt = S_CHK2;
      end
      S_CHK2: begin
        alu_a = {47'd0, ps_r};
        alu_b = {32'd0, rest_r};
        alu_sub = 1'b1;
        if (alu_cout) begin
          if (out_free) begin
            load_res = 1'b1;
            res_nxt.pointer2 = next_page_addr_r;
            res_nxt.last = 1'b1;
            st_nxt = S_IDLE;
          end
        end else begin
          st_nxt = S_NCALC;
        end
      end
      S_NCALC: begin
        alu_a = {32'd0, rest_r};
        alu_b = {47'd0, ps_r - PS_W'(1)};
        n_nxt = n_sum[26:0];
        st_nxt = S_CAP;
      end
      S_CAP: begin
        alu_a = {57'd0, cfg.pool_capacity};
        alu_b = {37'd0, n_r};
        alu_sub = 1'b1;
        if (!alu_cout) begin
          if (out_free) begin
            load_res = 1'b1;
            res_nxt.status = 1'b1;
            res_nxt.last = 1'b1;
            st_nxt = S_IDLE;
          end
        end else begin
          rem_nxt = n_r[6:0] - 7'd1;
          links_nxt = '0;
          st_nxt = S_LINKS;
        end
      end
      S_LINKS: begin
        alu_a = {57'd0, rem_r};
        alu_b = {51'd0, slots_m1};
        alu_sub = 1'b1;
        if (alu_cout) begin
          rem_nxt = alu_sum[6:0];
          links_nxt = links_r + 5'd1;
        end else begin
          st_nxt = S_TOTAL;
        end
      end
      S_TOTAL: begin
        if (total > 8'(MAX_RESULTS)) begin
          if (out_free) begin
            load_res = 1'b1;
            res_nxt.status = 1'b1;
            res_nxt.last = 1'b1;
            st_nxt = S_IDLE;
          end
        end else begin
          entries_left_nxt = n_r[6:0];
          slot_index_nxt = '0;
          list_page_addr_nxt = cfg.pool_base;
          slot_addr_nxt = cfg.pool_base;
          st_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (slot_index_r == slots_m1) begin
          alu_a = list_page_addr_r;
          alu_b = {47'd0, ps_r};
        end else begin
          alu_a = slot_addr_r;
          alu_b = 64'd8;
        end
        if (out_free) begin
          load_res = 1'b1;
          res_nxt.write_addr = slot_addr_r;
          res_nxt.write_valid = 1'b1;
          if (slot_index_r == slots_m1) begin
            res_nxt.write_value = alu_sum;
            list_page_addr_nxt = alu_sum;
            slot_addr_nxt = alu_sum;
            slot_index_nxt = '0;
          end else begin
            res_nxt.write_value = next_page_addr_r;
            slot_addr_nxt = alu_sum;
            slot_index_nxt = slot_index_r + 13'd1;
            entries_left_nxt = entries_left_r - 7'd1;
            if (entries_left_r == 7'd1) begin
              res_nxt.pointer2 = cfg.pool_base;
              res_nxt.last = 1'b1;
              st_nxt = S_IDLE;
            end else begin
              st_nxt = S_STEP;
            end
          end
        end
      end
      S_STEP: begin
        alu_a = next_page_addr_r;
        alu_b = {47'd0, ps_r};
        next_page_addr_nxt = alu_sum;
        st_nxt = S_WRITE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid_r <= 1'b0;
      entries_left_r <= '0;
      slot_index_r <= '0;
      next_page_addr_r <= '0;
      list_page_addr_r <= '0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= out_valid_nxt;
      entries_left_r <= entries_left_nxt;
      slot_index_r <= slot_index_nxt;
      next_page_addr_r <= next_page_addr_nxt;
      list_page_addr_r <= list_page_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    blen_r <= blen_nxt;
    sh_r <= sh_nxt;
    ps_r <= ps_nxt;
    first_r <= first_nxt;
    rest_r <= rest_nxt;
    n_r <= n_nxt;
    rem_r <= rem_nxt;
    links_r <= links_nxt;
    slot_addr_r <= slot_addr_nxt;
    if (load_res) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> rtl/prp_list_builder.sv
// Top level of the PRP list builder: configuration registers on an APB-style port
// and the sequencer. Depends on plb_pkg, plb_in_if, plb_out_if and plb_seq.
//
// The block takes one request at a time and is not ready until its last result
// has been handed to the result register. All wide sums and compares go through one
// shared 64-bit adder, so a request is worked through in steps: the first-page check,
// the next page address, the two-page check, the entry count and the pool capacity
// check, one step per list link counted and the total check against 64 results,
// then the list writes: a page address step after every data page entry but the
// last, and a write per link slot. A request whose data ends within two pages
// gets no list, and a request that fails a check gets an error result. The
// sequencer holds while the result register stays full and a new result is ready.
module prp_list_builder (
  input  logic        clk,
  input  logic        rst_n,
  plb_in_if.sink      in_chan,
  plb_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import plb_pkg::*;

  logic [4:0]  pg_log2_r;
  logic [63:0] pool_base_r;
  logic [6:0]  pool_capacity_r;
  logic [1:0]  reg_idx;
  logic        wr_en;
  cfg_t        cfg;
  res_t        res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_log2_r <= PG_LOG2_RST;
      pool_base_r <= POOL_BASE_RST;
      pool_capacity_r <= POOL_CAPACITY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PG_LOG2:       pg_log2_r <= pwdata[4:0];
        REG_POOL_BASE:     pool_base_r <= pwdata;
        REG_POOL_CAPACITY: pool_capacity_r <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PG_LOG2:       prdata = {59'd0, pg_log2_r};
      REG_POOL_BASE:     prdata = pool_base_r;
      REG_POOL_CAPACITY: prdata = {57'd0, pool_capacity_r};
      default:           prdata = 64'd0;
    endcase
  end

  assign cfg.pg_log2       = pg_log2_r;
  assign cfg.pool_base     = pool_base_r;
  assign cfg.pool_capacity = pool_capacity_r;

  plb_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_buffer_addr (in_chan.buffer_addr),
    .in_byte_length (in_chan.byte_length),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_res        (res)
  );

  assign out_chan.write_addr  = res.write_addr;
  assign out_chan.write_value = res.write_value;
  assign out_chan.write_valid = res.write_valid;
  assign out_chan.pointer2    = res.pointer2;
  assign out_chan.status      = res.status;
  assign out_chan.last        = res.last;

endmodule
